// ----- rtl/u2a_pkg.sv -----
// ---------------------------------------------------------------------------
// u2a_pkg
// Shared types, codes and character helpers for the integer-to-ASCII block.
// ---------------------------------------------------------------------------
package u2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int PREC_W     = 7;
    localparam int POS_W      = 6;
    localparam int CNT_W      = 6;

    // Conversion selector codes.
    localparam logic [1:0] CMD_DEC       = 2'd0;
    localparam logic [1:0] CMD_HEX_LOWER = 2'd1;
    localparam logic [1:0] CMD_HEX_UPPER = 2'd2;
    localparam logic [1:0] CMD_NONE      = 2'd3;

    localparam logic [7:0] ASCII_ZERO    = 8'd48;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_UPPER_A = 8'd65;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEN,
        ST_EMIT
    } state_t;

    // Maps one digit to its ASCII character for the given selector.
    function automatic logic [7:0] digit_char(input logic [1:0] cmd, input logic [3:0] d);
        logic [7:0] d8;
        logic [7:0] ch;
        d8 = {4'b0000, d};
        case (cmd)
            CMD_DEC:       ch = ASCII_ZERO + d8;
            CMD_HEX_LOWER: ch = (d < 4'd10) ? ASCII_ZERO + d8 : ASCII_LOWER_A + d8 - 8'd10;
            CMD_HEX_UPPER: ch = (d < 4'd10) ? ASCII_ZERO + d8 : ASCII_UPPER_A + d8 - 8'd10;
            default:       ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/u2a_dabble.sv -----
// ---------------------------------------------------------------------------
// u2a_dabble
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// ---------------------------------------------------------------------------
module u2a_dabble
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [u2a_pkg::VALUE_W-1:0]    value,
    output logic                           done,
    output logic [u2a_pkg::BCD_W-1:0]      bcd
);

    logic [u2a_pkg::VALUE_W-1:0] val_reg;
    logic [u2a_pkg::VALUE_W-1:0] val_next;
    logic [u2a_pkg::BCD_W-1:0]   bcd_reg;
    logic [u2a_pkg::BCD_W-1:0]   bcd_next;
    logic [u2a_pkg::BCD_W-1:0]   bcd_adj;
    logic [u2a_pkg::CNT_W-1:0]   cnt_reg;
    logic [u2a_pkg::CNT_W-1:0]   cnt_next;
    logic                        done_reg;
    logic                        done_next;

    // Every BCD digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < u2a_pkg::BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        val_next  = val_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next = value;
            bcd_next = '0;
            cnt_next = u2a_pkg::CNT_W'(u2a_pkg::VALUE_W);
        end
        else if (cnt_reg != '0)
        begin
            bcd_next  = {bcd_adj[u2a_pkg::BCD_W-2:0], val_reg[u2a_pkg::VALUE_W-1]};
            val_next  = {val_reg[u2a_pkg::VALUE_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == u2a_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ----- rtl/uint_to_ascii_digits_top.sv -----
// ---------------------------------------------------------------------------
// uint_to_ascii_digits_top
// Formats a 32-bit unsigned value as decimal or hex ASCII digits.
// ---------------------------------------------------------------------------
// The slave side takes one beat per number: the value and precision in
// s_tdata and the conversion selector in s_tuser. The master side returns one
// beat per character, most significant digit first, with m_tlast on the final
// character of the run. A zero value with zero precision, or the unused
// selector, gives a single beat with m_tuser set and character zero.
// Digits are zero-padded on the left to the precision, which saturates at
// MAX_PRECISION (never above 63); a negative precision means no padding.
// Decimal input runs through a bit-serial BCD converter before its length is
// found; hex input skips the converter, and an empty result goes straight to
// the emit step. Characters leave one per cycle, each picked by its position
// from the digit register, while the receiver takes them.
// A new number is taken only after the last character of the previous one is
// in the output register. When the receiver stalls, the output register holds
// its beat and the character count pauses. Reset empties the output register
// and returns the control to idle.
// ---------------------------------------------------------------------------
module uint_to_ascii_digits_top
#(
    parameter int MAX_PRECISION = 63
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], precision [38:32], zero fill [39]
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_out [7:0]
    output logic        m_tlast,
    output logic        m_tuser    // empty_res [0]
);

    localparam logic [u2a_pkg::POS_W-1:0] PREC_CAP =
        u2a_pkg::POS_W'((MAX_PRECISION < 63) ? MAX_PRECISION : 63);

    u2a_pkg::state_t                 state_reg, state_next;
    logic [1:0]                      cmd_reg, cmd_next;
    logic [u2a_pkg::POS_W-1:0]       prec_reg, prec_next;
    logic                            empty_reg, empty_next;
    logic [u2a_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [u2a_pkg::BCD_W-1:0]       digit_reg, digit_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [7:0]                      m_tdata_reg, m_tdata_next;
    logic                            m_tlast_reg, m_tlast_next;
    logic                            m_tuser_reg, m_tuser_next;

    logic [u2a_pkg::VALUE_W-1:0]     in_value;
    logic [u2a_pkg::PREC_W-1:0]      in_prec;
    logic [u2a_pkg::POS_W-1:0]       in_prec_eff;
    logic                            in_empty;
    logic                            conv_start;
    logic                            conv_done;
    logic [u2a_pkg::BCD_W-1:0]       conv_bcd;
    logic [3:0]                      sig_digits;
    logic [3:0]                      cur_digit;
    logic [u2a_pkg::POS_W-1:0]       char_count;
    logic                            out_free;

    assign in_value = s_tdata[31:0];
    assign in_prec  = s_tdata[38:32];
    assign in_empty = (s_tuser == u2a_pkg::CMD_NONE) ||
                      ((in_prec == '0) && (in_value == '0));

    always_comb
    begin
        if (in_prec[u2a_pkg::PREC_W-1])
            in_prec_eff = '0;
        else if (in_prec[u2a_pkg::POS_W-1:0] > PREC_CAP)
            in_prec_eff = PREC_CAP;
        else
            in_prec_eff = in_prec[u2a_pkg::POS_W-1:0];
    end

    u2a_dabble u_dabble
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .value (in_value),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    // Significant digits: position of the highest nonzero nibble, at least one.
    always_comb
    begin
        sig_digits = 4'd1;
        for (int i = 1; i < u2a_pkg::BCD_DIGITS; i++)
        begin
            if (digit_reg[4*i +: 4] != 4'd0)
                sig_digits = 4'(i + 1);
        end
    end

    // The digit that belongs to the current character position.
    always_comb
    begin
        cur_digit = 4'd0;
        for (int i = 0; i < u2a_pkg::BCD_DIGITS; i++)
        begin
            if (pos_reg == u2a_pkg::POS_W'(i))
                cur_digit = digit_reg[4*i +: 4];
        end
    end

    assign char_count = (prec_reg > {2'b00, sig_digits}) ? prec_reg : {2'b00, sig_digits};
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == u2a_pkg::ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        prec_next     = prec_reg;
        empty_next    = empty_reg;
        pos_next      = pos_reg;
        digit_next    = digit_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        conv_start    = 1'b0;

        case (state_reg)
            u2a_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    prec_next  = in_prec_eff;
                    empty_next = in_empty;
                    if (in_empty)
                    begin
                        pos_next   = '0;
                        state_next = u2a_pkg::ST_EMIT;
                    end
                    else if (s_tuser == u2a_pkg::CMD_DEC)
                    begin
                        conv_start = 1'b1;
                        state_next = u2a_pkg::ST_CONV;
                    end
                    else
                    begin
                        digit_next = {{(u2a_pkg::BCD_W-u2a_pkg::VALUE_W){1'b0}}, in_value};
                        state_next = u2a_pkg::ST_LEN;
                    end
                end
            end

            u2a_pkg::ST_CONV:
            begin
                if (conv_done)
                begin
                    digit_next = conv_bcd;
                    state_next = u2a_pkg::ST_LEN;
                end
            end

            u2a_pkg::ST_LEN:
            begin
                pos_next   = char_count - 1'b1;
                state_next = u2a_pkg::ST_EMIT;
            end

            u2a_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = (pos_reg == '0);
                    m_tuser_next  = empty_reg;
                    if (empty_reg)
                        m_tdata_next = 8'd0;
                    else if (pos_reg >= u2a_pkg::POS_W'(u2a_pkg::BCD_DIGITS))
                        m_tdata_next = u2a_pkg::ASCII_ZERO;
                    else
                        m_tdata_next = u2a_pkg::digit_char(cmd_reg, cur_digit);
                    if (pos_reg == '0)
                        state_next = u2a_pkg::ST_IDLE;
                    else
                        pos_next = pos_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = u2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= u2a_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        prec_reg    <= prec_next;
        empty_reg   <= empty_next;
        pos_reg     <= pos_next;
        digit_reg   <= digit_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/u2a_checker.sv -----
// ---------------------------------------------------------------------------
// u2a_checker
// Port-level checks for the integer-to-ASCII block, bound to the top level.
// ---------------------------------------------------------------------------
module u2a_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // A stalled beat stays on the bus.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

    // An empty result is always a single beat that closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
    else $error("empty result without last or with a character");

    // Every other beat carries a character from '0' to 'f', never a control code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata >= 8'd48) && (m_tdata <= 8'd102))
    else $error("character outside the digit range");

    // A new number is taken only once the last character of the previous run is in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !(m_tvalid && $past(m_tvalid && !m_tlast && m_tready)))
    else $error("input taken in the middle of a character run");

endmodule

bind uint_to_ascii_digits_top u2a_checker u_u2a_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ----- tb/tb_uint_to_ascii_digits_top.sv -----
// ---------------------------------------------------------------------------
// tb_uint_to_ascii_digits_top
// Self-checking bench for the integer-to-ASCII digit formatter.
// ---------------------------------------------------------------------------
// Numbers go in on the slave stream and each one is turned into the expected
// string of character beats. That prediction is built as soon as the input
// beat is taken. Every character beat on the master stream is checked against
// the oldest predicted beat. The run has five parts, in this order:
//   - directed corner cases;
//   - a long receiver hold-off that makes the block stall its input;
//   - a sender pause that lets the block drain completely;
//   - random numbers, with a stretch where neither side idles;
//   - a drain at the end.
// A watchdog ends the run if no beat moves on either side for too long.
// ---------------------------------------------------------------------------
module tb_uint_to_ascii_digits_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PREC      = 63;
    localparam int RANDOM_ITEMS  = 450;
    localparam int QUIET_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 120;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty;
    } char_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // value [31:0], precision [38:32], zero fill [39]
    logic [1:0]  s_tuser;   // cmd [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // char_out [7:0]
    logic        m_tlast;
    logic        m_tuser;   // empty_res [0]

    char_beat_t  expected_chars[$];
    int          error_count = 0;
    bit          send_gaps = 1'b1;
    bit          recv_gaps = 1'b1;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    uint_to_ascii_digits_top #(
        .MAX_PRECISION (MAX_PREC)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Appends the character beats that one number should produce.
    function automatic void predict_digits(input logic [31:0] value, input logic [1:0] cmd,
                                           input logic signed [6:0] prec);
        int unsigned base;
        int          min_len;
        int unsigned d;
        logic [31:0] rest;
        logic [7:0]  text[$];
        char_beat_t  beat;
        min_len = prec;
        if (cmd == u2a_pkg::CMD_NONE || (prec == 0 && value == 32'd0))
        begin
            beat.ch    = 8'd0;
            beat.last  = 1'b1;
            beat.empty = 1'b1;
            expected_chars.push_back(beat);
            return;
        end
        if (min_len > MAX_PREC)
            min_len = MAX_PREC;
        base = (cmd == u2a_pkg::CMD_DEC) ? 10 : 16;
        rest = value;
        do
        begin
            d    = rest % base;
            rest = rest / base;
            if (d < 10)
                text.push_front(u2a_pkg::ASCII_ZERO + 8'(d));
            else if (cmd == u2a_pkg::CMD_HEX_LOWER)
                text.push_front(u2a_pkg::ASCII_LOWER_A + 8'(d - 10));
            else
                text.push_front(u2a_pkg::ASCII_UPPER_A + 8'(d - 10));
        end
        while (rest != 32'd0);
        while (text.size() < min_len)
            text.push_front(u2a_pkg::ASCII_ZERO);
        foreach (text[i])
        begin
            beat.ch    = text[i];
            beat.last  = (i == text.size() - 1);
            beat.empty = 1'b0;
            expected_chars.push_back(beat);
        end
    endfunction

    // Watches both streams: predicts on every input beat, checks every output beat.
    always @(posedge clk)
    begin : char_check
        char_beat_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_digits(s_tdata[31:0], s_tuser, s_tdata[38:32]);
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character beat: char_out %0d, last %0b, empty_res %0b",
                           m_tdata, m_tlast, m_tuser);
                    error_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.ch)
                    begin
                        $error("char_out: expected %0d, got %0d", want.ch, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        error_count++;
                    end
                    if (m_tuser !== want.empty)
                    begin
                        $error("empty_res: expected %0b, got %0b", want.empty, m_tuser);
                        error_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off each time a test asks for one.
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_seen = hold_req;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (recv_gaps)
            m_tready <= ($urandom_range(99) >= 25);
        else
            m_tready <= 1'b1;
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("uint_to_ascii_digits_top verification failed");
        $finish;
    end

    // Offers one number and returns at the edge where the beat is taken.
    task automatic send_number(input logic [31:0] value, input logic [1:0] cmd,
                               input logic signed [6:0] prec);
        while (send_gaps && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, prec, value};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_number(32'd0,          u2a_pkg::CMD_DEC,       7'sd0);
        send_number(32'd0,          u2a_pkg::CMD_HEX_LOWER, 7'sd0);
        send_number(32'd0,          u2a_pkg::CMD_DEC,       -7'sd1);
        send_number(32'd0,          u2a_pkg::CMD_HEX_UPPER, -7'sd64);
        send_number(32'd0,          u2a_pkg::CMD_DEC,       7'sd1);
        send_number(32'd0,          u2a_pkg::CMD_DEC,       7'sd63);
        send_number(32'hFFFF_FFFF,  u2a_pkg::CMD_DEC,       -7'sd1);
        send_number(32'hFFFF_FFFF,  u2a_pkg::CMD_HEX_LOWER, -7'sd1);
        send_number(32'hFFFF_FFFF,  u2a_pkg::CMD_HEX_UPPER, 7'sd63);
        send_number(32'hDEAD_BEEF,  u2a_pkg::CMD_HEX_LOWER, 7'sd0);
        send_number(32'hABCD_EF01,  u2a_pkg::CMD_HEX_UPPER, 7'sd12);
        send_number(32'd12345,      u2a_pkg::CMD_DEC,       7'sd3);
        send_number(32'd7,          u2a_pkg::CMD_DEC,       7'sd10);
        send_number(32'd1000000000, u2a_pkg::CMD_DEC,       7'sd5);
        send_number(32'h8000_0000,  u2a_pkg::CMD_DEC,       7'sd62);
        send_number(32'd15,         u2a_pkg::CMD_HEX_LOWER, 7'sd2);
        send_number(32'd10,         u2a_pkg::CMD_HEX_UPPER, 7'sd1);
        send_number(32'd1,          u2a_pkg::CMD_HEX_LOWER, -7'sd5);
        // The unused selector gives an empty beat whatever the value.
        send_number(32'hFFFF_FFFF,  u2a_pkg::CMD_NONE,      7'sd5);
        send_number(32'd0,          u2a_pkg::CMD_NONE,      7'sd0);
        send_number(32'd0,          u2a_pkg::CMD_NONE,      -7'sd1);
        wait_drained();
    endtask

    // The receiver stops while numbers keep coming, so the block must stall its input.
    task automatic test_output_stall();
        hold_req++;
        for (int i = 0; i < 6; i++)
            send_number($urandom, u2a_pkg::CMD_DEC, 7'($urandom_range(20)));
        wait_drained();
    endtask

    task automatic test_pause_and_resume();
        send_number($urandom, u2a_pkg::CMD_HEX_UPPER, 7'sd9);
        send_number($urandom, u2a_pkg::CMD_DEC, -7'sd1);
        wait_drained();
        send_number($urandom, u2a_pkg::CMD_HEX_LOWER, 7'sd0);
        send_number(32'd0, u2a_pkg::CMD_DEC, 7'sd0);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [31:0]       value;
        logic [1:0]        cmd;
        logic signed [6:0] prec;
        int unsigned       pow10;
        int                r;
        for (int i = 0; i < count; i++)
        begin
            // A stretch in the middle runs with no idling on either side.
            if (i == count / 4)
            begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            else if (i == count / 2)
            begin
                send_gaps = 1'b1;
                recv_gaps = 1'b1;
            end

            case ($urandom_range(3))
                0: value = $urandom;
                1: value = $urandom_range(20);
                2: value = $urandom >> $urandom_range(31);
                default:
                begin
                    // Values next to a power of ten change the decimal digit count.
                    pow10 = 1;
                    repeat ($urandom_range(9))
                        pow10 = pow10 * 10;
                    value = pow10 - $urandom_range(1);
                end
            endcase

            r = $urandom_range(99);
            if (r < 5)
                cmd = u2a_pkg::CMD_NONE;
            else if (r < 45)
                cmd = u2a_pkg::CMD_DEC;
            else if (r < 72)
                cmd = u2a_pkg::CMD_HEX_LOWER;
            else
                cmd = u2a_pkg::CMD_HEX_UPPER;

            r = $urandom_range(99);
            if (r < 20)
                prec = -7'sd1;
            else if (r < 27)
                prec = 7'(-int'($urandom_range(64, 1)));
            else if (r < 92)
                prec = 7'($urandom_range(12));
            else
                prec = 7'($urandom_range(63));

            send_number(value, cmd, prec);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = u2a_pkg::CMD_DEC;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_stall();
        test_pause_and_resume();
        test_random(RANDOM_ITEMS);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_chars.size() == 0)
            $display("uint_to_ascii_digits_top verification clean");
        else
            $display("uint_to_ascii_digits_top verification failed");
        $finish;
    end

endmodule
